// ===== hdl/pds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the power domain sequencer.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned NUM_RAILS       = 4;
  localparam int unsigned DELAY_WIDTH_DEF = 16;
  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 2;

  // delay reset values
  localparam int unsigned DELAY_RST_AN_POS = 5;
  localparam int unsigned DELAY_RST_AN_NEG = 5;
  localparam int unsigned DELAY_RST_HV     = 200;
  localparam int unsigned DELAY_RST_LED    = 5;

  // rail numbering
  localparam int unsigned RAIL_AN_POS = 0;
  localparam int unsigned RAIL_AN_NEG = 1;
  localparam int unsigned RAIL_HV     = 2;
  localparam int unsigned RAIL_LED    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DELAY_AN_POS = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DELAY_AN_NEG = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DELAY_HV     = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DELAY_LED    = 2'd3;

  typedef enum logic [1:0] {
    RAIL_OFF   = 2'd0,
    RAIL_TRANS = 2'd1,
    RAIL_READY = 2'd2,
    RAIL_ERROR = 2'd3
  } rail_state_e;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SW_ANALOG  = 3'd1,
    OP_SW_HV      = 3'd2,
    OP_SW_LED     = 3'd3,
    OP_QRY_ANALOG = 3'd4,
    OP_QRY_HV     = 3'd5,
    OP_QRY_LED    = 3'd6
  } op_e;

  // per-rail command for one word
  typedef struct packed {
    logic tick;
    logic switch_req;
    logic settle;
    logic force_err;
    logic turn_on;
  } rail_cmd_t;

endpackage : pds_pkg
`default_nettype wire

// ===== hdl/pds_rail.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_rail
// State, direction, delay counter and enable pin of one power rail.
// ----------------------------------------------------------------------------
module pds_rail #(
  parameter int unsigned DelayWidth = pds_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,   // word accepted this cycle
  input  wire pds_pkg::rail_cmd_t      cmd_i,
  input  wire logic [DelayWidth-1:0]   delay_i,
  output pds_pkg::rail_state_e         state_o,  // state after this word
  output logic                         enable_o  // enable after this word
);

  pds_pkg::rail_state_e    state_q, state_d;
  logic                    dir_q, dir_d;
  logic                    en_q, en_d;
  logic [DelayWidth-1:0]   rem_q, rem_d;
  logic                    settled;

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    en_d    = en_q;
    rem_d   = rem_q;
    settled = (cmd_i.turn_on && state_q == pds_pkg::RAIL_READY) ||
              (!cmd_i.turn_on && state_q == pds_pkg::RAIL_OFF);
    if (cmd_i.tick && rem_q != '0) begin
      rem_d = rem_q - DelayWidth'(1);
    end
    if (cmd_i.switch_req && !settled) begin
      en_d    = cmd_i.turn_on;
      dir_d   = cmd_i.turn_on;
      state_d = pds_pkg::RAIL_TRANS;
      rem_d   = delay_i;
    end
    if (cmd_i.settle) begin
      if (state_q == pds_pkg::RAIL_TRANS && rem_q == '0) begin
        state_d = dir_q ? pds_pkg::RAIL_READY : pds_pkg::RAIL_OFF;
      end
      // power-good low overrides whatever settling gave
      if (cmd_i.force_err) begin
        state_d = pds_pkg::RAIL_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pds_pkg::RAIL_OFF;
      dir_q   <= 1'b0;
      en_q    <= 1'b0;
      rem_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      dir_q   <= dir_d;
      en_q    <= en_d;
      rem_q   <= rem_d;
    end
  end

  assign state_o  = state_d;
  assign enable_o = en_d;

endmodule : pds_rail
`default_nettype wire

// ===== hdl/power_domain_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// power_domain_sequencer
// Sequencer for four power rails with delay-timed on/off transitions.
// ----------------------------------------------------------------------------
// Takes one command word per cycle (tick, switch or query) and returns one
// result word per command: the queried status and the four enable levels.
// A command is applied to the rail registers in the cycle it is accepted and
// its result is written to the output register along with them; the sole limit is
// that output register, so the input stalls only while a result waits unread.
// Delay registers are written on the cfg channel, which never stalls.
module power_domain_sequencer #(
  parameter int unsigned DelayWidth = pds_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // command stream
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  wire logic [7:0]                            s_axis_tdata_i, // [0] turn_on, [1] power_good
  input  wire logic [2:0]                            s_axis_tuser_i, // [2:0] op
  // result stream
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  output logic [7:0]                                 m_axis_tdata_o, // [1:0] status, [5:2] enables
  // configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [pds_pkg::CFG_IDX_WIDTH-1:0]     cfg_index_i,
  input  wire logic [pds_pkg::CFG_DATA_WIDTH-1:0]    cfg_data_i
);

  localparam int unsigned NR = pds_pkg::NUM_RAILS;

  logic [DelayWidth-1:0]     delay_q [NR];
  logic [DelayWidth-1:0]     delay_rst [NR];
  pds_pkg::rail_cmd_t        cmd [NR];
  pds_pkg::rail_state_e      rail_st [NR];
  logic [NR-1:0]             rail_en;
  pds_pkg::op_e              op;
  logic                      turn_on, pgood, step, query;
  logic [1:0]                status;
  logic                      m_valid_q;
  logic [1:0]                status_q;
  logic [NR-1:0]             enables_q;

  assign delay_rst[pds_pkg::RAIL_AN_POS] = DelayWidth'(pds_pkg::DELAY_RST_AN_POS);
  assign delay_rst[pds_pkg::RAIL_AN_NEG] = DelayWidth'(pds_pkg::DELAY_RST_AN_NEG);
  assign delay_rst[pds_pkg::RAIL_HV]     = DelayWidth'(pds_pkg::DELAY_RST_HV);
  assign delay_rst[pds_pkg::RAIL_LED]    = DelayWidth'(pds_pkg::DELAY_RST_LED);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NR; i++) delay_q[i] <= delay_rst[i];
    end else if (cfg_valid_i) begin
      delay_q[cfg_index_i] <= DelayWidth'(cfg_data_i);
    end
  end

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign step    = s_axis_tvalid_i && s_axis_tready_o;
  assign op      = pds_pkg::op_e'(s_axis_tuser_i);
  assign turn_on = s_axis_tdata_i[0];
  assign pgood   = s_axis_tdata_i[1];

  always_comb begin
    query = 1'b0;
    for (int i = 0; i < NR; i++) begin
      cmd[i] = '{tick: 1'b0, switch_req: 1'b0, settle: 1'b0,
                 force_err: 1'b0, turn_on: turn_on};
    end
    unique case (op)
      pds_pkg::OP_TICK: begin
        for (int i = 0; i < NR; i++) cmd[i].tick = 1'b1;
      end
      pds_pkg::OP_SW_ANALOG: begin
        cmd[pds_pkg::RAIL_AN_POS].switch_req = 1'b1;
        cmd[pds_pkg::RAIL_AN_NEG].switch_req = 1'b1;
      end
      pds_pkg::OP_SW_HV:  cmd[pds_pkg::RAIL_HV].switch_req  = 1'b1;
      pds_pkg::OP_SW_LED: cmd[pds_pkg::RAIL_LED].switch_req = 1'b1;
      pds_pkg::OP_QRY_ANALOG, pds_pkg::OP_QRY_HV, pds_pkg::OP_QRY_LED: begin
        query = 1'b1;
        for (int i = 0; i < NR; i++) cmd[i].settle = 1'b1;
        cmd[pds_pkg::RAIL_HV].force_err = !pgood;
      end
      default: ;  // unused op: no effect
    endcase
  end

  for (genvar g = 0; g < NR; g++) begin : g_rail
    pds_rail #(
      .DelayWidth(DelayWidth)
    ) u_rail (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .cmd_i   (cmd[g]),
      .delay_i (delay_q[g]),
      .state_o (rail_st[g]),
      .enable_o(rail_en[g])
    );
  end

  always_comb begin
    status = pds_pkg::RAIL_OFF;
    if (query) begin
      unique case (op)
        pds_pkg::OP_QRY_HV:  status = rail_st[pds_pkg::RAIL_HV];
        pds_pkg::OP_QRY_LED: status = rail_st[pds_pkg::RAIL_LED];
        default: begin
          // analog pair: off wins, then both ready, else in transition
          priority if (rail_st[pds_pkg::RAIL_AN_POS] == pds_pkg::RAIL_OFF ||
                       rail_st[pds_pkg::RAIL_AN_NEG] == pds_pkg::RAIL_OFF) begin
            status = pds_pkg::RAIL_OFF;
          end else if (rail_st[pds_pkg::RAIL_AN_POS] == pds_pkg::RAIL_READY &&
                       rail_st[pds_pkg::RAIL_AN_NEG] == pds_pkg::RAIL_READY) begin
            status = pds_pkg::RAIL_READY;
          end else begin
            status = pds_pkg::RAIL_TRANS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      m_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q  <= status;
      enables_q <= rail_en;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, enables_q, status_q};

endmodule : power_domain_sequencer
`default_nettype wire

// ===== hdl/pds_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the power domain sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [7:0] s_axis_tdata_i,
  input wire logic [2:0] s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // non-query words (tick, switch, unused op) report status off
  a_nonquery_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o &&
     s_axis_tuser_i != pds_pkg::OP_QRY_ANALOG &&
     s_axis_tuser_i != pds_pkg::OP_QRY_HV &&
     s_axis_tuser_i != pds_pkg::OP_QRY_LED)
    |=> (m_axis_tvalid_o && m_axis_tdata_o[1:0] == pds_pkg::RAIL_OFF))
    else $error("non-query word returned nonzero status");

  // power-good low at a high-voltage query reads error
  a_pgood_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o &&
     s_axis_tuser_i == pds_pkg::OP_QRY_HV && !s_axis_tdata_i[1])
    |=> (m_axis_tdata_o[1:0] == pds_pkg::RAIL_ERROR))
    else $error("high-voltage rail not in error with power-good low");

  // analog rails are always switched together
  a_analog_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2] == m_axis_tdata_o[3]))
    else $error("analog enables disagree");

  // empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result word changed");

endmodule : pds_checker

bind power_domain_sequencer pds_checker u_pds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the power domain sequencer.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream. Results come out on the master stream.
// An in-bench rail model predicts each result word when its command is
// accepted. Each result is then compared with the oldest prediction.
// The run starts with a directed table at the reset delays. After that come
// four random phases, each with its own set of delay registers: all zero,
// all ones, and two sets of small values. Most random words form switch,
// tick and query sequences. The rest are single random commands.
// Both streams idle in random bursts, and one long receiver hold-off fills
// the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         HOLD_CYCLES = 40;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] enables;
  } rail_result_t;

  typedef struct packed {
    logic         typed;
    rail_result_t want;
  } word_hint_t;

  typedef struct packed {
    logic [2:0] op;
    logic       on;
    logic       pg;
    logic       typed;
    logic [1:0] status;
    logic [3:0] enables;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;  // [0] turn_on, [1] power_good
  logic [2:0]  s_axis_tuser_i  = '0;  // [2:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [1:0] status, [5:2] enables
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [pds_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i = '0;
  logic [pds_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i  = '0;

  power_domain_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- rail model
  logic [15:0] delay_ticks [pds_pkg::NUM_RAILS] = '{16'(pds_pkg::DELAY_RST_AN_POS),
                                                    16'(pds_pkg::DELAY_RST_AN_NEG),
                                                    16'(pds_pkg::DELAY_RST_HV),
                                                    16'(pds_pkg::DELAY_RST_LED)};
  pds_pkg::rail_state_e rail_mode [pds_pkg::NUM_RAILS] =
    '{pds_pkg::RAIL_OFF, pds_pkg::RAIL_OFF, pds_pkg::RAIL_OFF, pds_pkg::RAIL_OFF};
  logic        rail_rising [pds_pkg::NUM_RAILS] = '{1'b0, 1'b0, 1'b0, 1'b0};
  logic [15:0] ticks_left  [pds_pkg::NUM_RAILS] = '{16'd0, 16'd0, 16'd0, 16'd0};
  logic [3:0]  enable_lvl  = 4'h0;

  function automatic void settle_one(int unsigned r);
    if (rail_mode[r] == pds_pkg::RAIL_TRANS && ticks_left[r] == 16'd0) begin
      if (rail_rising[r]) rail_mode[r] = pds_pkg::RAIL_READY;
      else rail_mode[r] = pds_pkg::RAIL_OFF;
    end
  endfunction

  // rails settle in order; power-good is applied before the LED rail
  function automatic void settle_rails(logic pg);
    settle_one(pds_pkg::RAIL_AN_POS);
    settle_one(pds_pkg::RAIL_AN_NEG);
    settle_one(pds_pkg::RAIL_HV);
    if (!pg) rail_mode[pds_pkg::RAIL_HV] = pds_pkg::RAIL_ERROR;
    settle_one(pds_pkg::RAIL_LED);
  endfunction

  function automatic void request_rail(int unsigned r, logic on);
    if ((on && rail_mode[r] == pds_pkg::RAIL_READY) ||
        (!on && rail_mode[r] == pds_pkg::RAIL_OFF)) return;
    enable_lvl[r]  = on;
    rail_mode[r]   = pds_pkg::RAIL_TRANS;
    rail_rising[r] = on;
    ticks_left[r]  = delay_ticks[r];
  endfunction

  function automatic rail_result_t power_step(logic [2:0] op, logic on, logic pg);
    rail_result_t res;
    res.status = pds_pkg::RAIL_OFF;
    case (op)
      pds_pkg::OP_TICK: begin
        for (int unsigned r = 0; r < pds_pkg::NUM_RAILS; r++)
          if (ticks_left[r] != 16'd0) ticks_left[r] = ticks_left[r] - 16'd1;
      end
      pds_pkg::OP_SW_ANALOG: begin
        request_rail(pds_pkg::RAIL_AN_POS, on);
        request_rail(pds_pkg::RAIL_AN_NEG, on);
      end
      pds_pkg::OP_SW_HV:  request_rail(pds_pkg::RAIL_HV, on);
      pds_pkg::OP_SW_LED: request_rail(pds_pkg::RAIL_LED, on);
      pds_pkg::OP_QRY_ANALOG: begin
        settle_rails(pg);
        if (rail_mode[pds_pkg::RAIL_AN_POS] == pds_pkg::RAIL_OFF ||
            rail_mode[pds_pkg::RAIL_AN_NEG] == pds_pkg::RAIL_OFF)
          res.status = pds_pkg::RAIL_OFF;
        else if (rail_mode[pds_pkg::RAIL_AN_POS] == pds_pkg::RAIL_READY &&
                 rail_mode[pds_pkg::RAIL_AN_NEG] == pds_pkg::RAIL_READY)
          res.status = pds_pkg::RAIL_READY;
        else
          res.status = pds_pkg::RAIL_TRANS;
      end
      pds_pkg::OP_QRY_HV: begin
        settle_rails(pg);
        res.status = rail_mode[pds_pkg::RAIL_HV];
      end
      pds_pkg::OP_QRY_LED: begin
        settle_rails(pg);
        res.status = rail_mode[pds_pkg::RAIL_LED];
      end
      default: ;
    endcase
    res.enables = enable_lvl;
    return res;
  endfunction

  // -------------------------------------------------------------- scoreboard
  rail_result_t pending_results [$];
  word_hint_t   word_hints      [$];
  int           fail_count = 0;

  always @(posedge clk_i) begin
    rail_result_t got;
    rail_result_t want;
    word_hint_t   hint;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status  = m_axis_tdata_o[1:0];
        got.enables = m_axis_tdata_o[5:2];
        if (pending_results.size() == 0) begin
          $display("%0t: result word %h with nothing pending", $time, m_axis_tdata_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.enables !== want.enables) begin
            $display("%0t: enables mismatch: expected %b actual %b",
                     $time, want.enables, got.enables);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) delay_ticks[cfg_index_i] = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = power_step(s_axis_tuser_i, s_axis_tdata_i[0], s_axis_tdata_i[1]);
        hint = word_hints.pop_front();
        // directed rows with a hand-typed result are checked against that value
        pending_results.push_back(hint.typed ? hint.want : want);
      end
    end
  end

  // ------------------------------------------------------------ result side
  logic idle_on  = 1'b1;
  logic hold_req = 1'b0;

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // ------------------------------------------------------------ command side
  task automatic send_word(input logic [2:0] op, input logic on, input logic pg,
                           input logic typed, input rail_result_t want);
    word_hint_t hint;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    hint.typed = typed;
    hint.want  = want;
    word_hints.push_back(hint);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'b0, pg, on};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random(input logic [2:0] op, input logic pg);
    send_word(op, 1'($urandom_range(0, 1)), pg, 1'b0, '0);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0 || word_hints.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_delays(input logic [15:0] d0, input logic [15:0] d1,
                              input logic [15:0] d2, input logic [15:0] d3);
    logic [15:0] vals [pds_pkg::NUM_RAILS];
    vals = '{d0, d1, d2, d3};
    for (int unsigned i = 0; i < pds_pkg::NUM_RAILS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[pds_pkg::CFG_IDX_WIDTH-1:0];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly switch / tick / query runs, the rest single random commands
  task automatic run_random(input int n_words);
    int          sent;
    int          k;
    int unsigned dly;
    logic [2:0]  sw_op;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) < 6) begin
        sw_op = 3'($urandom_range(pds_pkg::OP_SW_ANALOG, pds_pkg::OP_SW_LED));
        case (sw_op)
          pds_pkg::OP_SW_ANALOG:
            dly = (delay_ticks[pds_pkg::RAIL_AN_POS] > delay_ticks[pds_pkg::RAIL_AN_NEG]) ?
                  delay_ticks[pds_pkg::RAIL_AN_POS] : delay_ticks[pds_pkg::RAIL_AN_NEG];
          pds_pkg::OP_SW_HV: dly = delay_ticks[pds_pkg::RAIL_HV];
          default:           dly = delay_ticks[pds_pkg::RAIL_LED];
        endcase
        k = (dly > 10) ? 10 : int'(dly);
        k = k + $urandom_range(0, 2) - 1;
        if (k < 0) k = 0;
        send_random(sw_op, 1'b1);
        repeat (k) send_random(pds_pkg::OP_TICK, 1'($urandom_range(0, 1)));
        send_random(sw_op + 3'd3, 1'($urandom_range(0, 9) != 0));
        sent += k + 2;
      end else begin
        send_random(3'($urandom_range(0, 7)), 1'($urandom_range(0, 5) != 0));
        sent++;
      end
    end
  endtask

  initial begin
    stim_row_t directed_rows [25];
    directed_rows = '{
      '{pds_pkg::OP_QRY_ANALOG, 1'b0, 1'b1, 1'b1, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_HV,     1'b1, 1'b1, 1'b1, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_LED,    1'b0, 1'b1, 1'b1, pds_pkg::RAIL_OFF,   4'b0000},
      '{OP_UNUSED,              1'b1, 1'b0, 1'b1, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_SW_ANALOG,  1'b1, 1'b1, 1'b1, pds_pkg::RAIL_OFF,   4'b0011},
      // reload mid-transition
      '{pds_pkg::OP_SW_ANALOG,  1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_ANALOG, 1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b0, 1'b0, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b1, 1'b0, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_ANALOG, 1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      // already ready: ignored
      '{pds_pkg::OP_SW_ANALOG,  1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      // power-good low on an off rail
      '{pds_pkg::OP_QRY_HV,     1'b0, 1'b0, 1'b1, pds_pkg::RAIL_ERROR, 4'b0011},
      // out of error
      '{pds_pkg::OP_SW_HV,      1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_HV,     1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_SW_HV,      1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_SW_LED,     1'b1, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_LED,    1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_SW_ANALOG,  1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_ANALOG, 1'b0, 1'b1, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_SW_LED,     1'b0, 1'b0, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_TICK,       1'b1, 1'b0, 1'b0, pds_pkg::RAIL_OFF,   4'b0000},
      '{pds_pkg::OP_QRY_LED,    1'b0, 1'b0, 1'b0, pds_pkg::RAIL_OFF,   4'b0000}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].on, directed_rows[i].pg,
                directed_rows[i].typed, {directed_rows[i].status, directed_rows[i].enables});
    wait_idle();

    // zero delays: transitions finish at the next query
    write_delays(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(130);
    wait_idle();

    // longest delays, no idling
    idle_on = 1'b0;
    write_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100);
    wait_idle();

    // uneven small delays; long receiver hold-off at the start
    idle_on = 1'b1;
    write_delays(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                 16'($urandom_range(0, 9)), 16'($urandom_range(0, 7)));
    hold_req = 1'b1;
    run_random(160);
    wait_idle();

    idle_on = 1'b0;
    write_delays(16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
                 16'($urandom_range(1, 12)), 16'($urandom_range(1, 10)));
    run_random(160);
    wait_idle();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pds_pkg.sv
hdl/pds_rail.sv
hdl/power_domain_sequencer.sv
hdl/pds_checker.sv
tb/tb.sv
